FILE: rtl/core/exact_color_palette_builder_defines.svh
// Assertion macros for the exact color palette builder.
`ifndef EXACT_COLOR_PALETTE_BUILDER_DEFINES_SVH
`define EXACT_COLOR_PALETTE_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define ECPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecpb assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define ECPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecpb assertion failed");
`else
`define ECPB_ASSERT_NOW(lbl, ante, cons)
`define ECPB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/ecpb_pkg.sv
// Shared types, codes and helpers of the exact color palette builder.
package ecpb_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 9;
  localparam int unsigned IdxW   = 8;

  // action codes
  localparam logic [1:0] ActPixel = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  // register indexes
  localparam logic RegConvertAlpha  = 1'b0;
  localparam logic RegPaletteEntries = 1'b1;

  localparam logic [7:0] SwzKeep = 8'hE7;
  localparam logic [7:0] SwzBit3 = 8'h08;
  localparam logic [7:0] SwzBit4 = 8'h10;

  // broadcast to every cell while one item travels the chain
  typedef struct packed {
    logic              pixel;    // 1: search for word, 0: read at rd_idx
    logic [WordW-1:0]  word;     // search key, also write data
    logic [CountW-1:0] used;
    logic [IdxW-1:0]   rd_idx;
    logic              rd_ok;
    logic              we;
    logic [IdxW-1:0]   wr_addr;
  } ctl_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [WordW-1:0] payload;  // matched index (pixel) or entry (read)
  } tok_t;

  // file position to entry index: swap bits 3 and 4
  function automatic logic [7:0] swizzle(input logic [7:0] p);
    swizzle = (p & SwzKeep) | ((p & SwzBit3) << 1) | ((p & SwzBit4) >> 1);
  endfunction

endpackage

FILE: rtl/core/ecpb_cell.sv
// One palette cell: holds an entry, checks the passing token, hands it on.
module ecpb_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ecpb_pkg::ctl_t ctl_i,
  input  logic           tok_vld_i,
  input  ecpb_pkg::tok_t tok_i,
  output logic           tok_vld_o,
  output ecpb_pkg::tok_t tok_o
);

  logic [ecpb_pkg::WordW-1:0] entry_q;
  logic                       vld_q;
  ecpb_pkg::tok_t             tok_q, tok_d;
  logic                       in_use, match;

  assign in_use = ecpb_pkg::CountW'(IDX) < ctl_i.used;

  always_comb begin
    if (ctl_i.pixel) begin
      match = in_use && !tok_i.hit && (entry_q == ctl_i.word);
    end else begin
      match = ctl_i.rd_ok && (ctl_i.rd_idx == ecpb_pkg::IdxW'(IDX));
    end
    tok_d = tok_i;
    if (match) begin
      tok_d.hit = 1'b1;
      if (ctl_i.pixel) begin
        tok_d.payload = ecpb_pkg::WordW'(IDX);
      end else begin
        tok_d.payload = entry_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (ctl_i.we && ctl_i.wr_addr == ecpb_pkg::IdxW'(IDX)) begin
      entry_q <= ctl_i.word;
    end
  end

  assign tok_vld_o = vld_q;
  assign tok_o     = tok_q;

endmodule

FILE: rtl/core/exact_color_palette_builder.sv
// Top level: item control, configuration registers and the chain of palette cells.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------
//   input    | in_valid_i/ready_o  | action, red, green, blue, alpha, position
//   result   | out_valid_o/ready_i | index, added, full_res, entry_*, used_total
//   config   | APB psel/penable    | convert_alpha @0x0, palette_entries @0x4
//
// out_valid_o rises once a token has walked the cell chain, one cell per cycle, and the
// result has been formed. A new item is taken only once the last one has left the chain.
// One item is in work at a time; a new one is taken while a result waits.
// A stalled result holds completion of the next item, and the table with it.
// Reset empties the table (count zero); entries need no clearing.
`include "exact_color_palette_builder_defines.svh"

module exact_color_palette_builder #(
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  index_o,
  output logic        added_o,
  output logic        full_res_o,
  output logic [7:0]  entry_red_o,
  output logic [7:0]  entry_green_o,
  output logic [7:0]  entry_blue_o,
  output logic [7:0]  entry_alpha_o,
  output logic [8:0]  used_total_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  localparam logic [8:0] MaxCnt = 9'(MAX_COLORS);

  state_e state_q;
  logic   conv_q;
  logic [8:0] pent_q;
  logic [8:0] used_q;
  logic [8:0] lim;
  logic       start_q;
  logic [1:0] act_q;
  logic [31:0] word_q;
  logic [7:0]  rdi_q;
  logic        rdok_q;
  logic        res_hit_q;
  logic [31:0] res_pay_q;
  logic        out_valid_q, added_q, full_q;
  logic [7:0]  index_q;
  logic [31:0] entry_q;
  logic        wr_cfg, accept, finish, append;
  logic [7:0]  alpha_c, pos_idx;
  ecpb_pkg::ctl_t ctl;

  logic [MAX_COLORS:0]  tok_vld;
  ecpb_pkg::tok_t       tok [MAX_COLORS+1];

  // configuration
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b1;
      pent_q <= 9'd256;
    end else if (wr_cfg) begin
      case (paddr[2])
        ecpb_pkg::RegConvertAlpha:   conv_q <= pwdata[0];
        ecpb_pkg::RegPaletteEntries: pent_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ecpb_pkg::RegConvertAlpha:   prdata = {31'd0, conv_q};
      ecpb_pkg::RegPaletteEntries: prdata = {23'd0, pent_q};
      default:                     prdata = 32'd0;
    endcase
  end

  assign lim = (pent_q > MaxCnt) ? MaxCnt : pent_q;

  // item control
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign append     = (act_q == ecpb_pkg::ActPixel) && !res_hit_q && (used_q < lim);
  assign alpha_c    = conv_q ? {1'b0, alpha_i[7:1]} : alpha_i;
  assign pos_idx    = ecpb_pkg::swizzle(position_i);

  always_comb begin
    ctl.pixel   = (act_q == ecpb_pkg::ActPixel);
    ctl.word    = word_q;
    ctl.used    = used_q;
    ctl.rd_idx  = rdi_q;
    ctl.rd_ok   = rdok_q && (act_q == ecpb_pkg::ActRead);
    ctl.we      = finish && append;
    ctl.wr_addr = used_q[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      used_q      <= 9'd0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok_vld[MAX_COLORS]) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            state_q <= S_IDLE;
            if (act_q == ecpb_pkg::ActClear) begin
              used_q <= 9'd0;
            end else if (append) begin
              used_q <= used_q + 9'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      word_q <= {alpha_c, blue_i, green_i, red_i};
      rdi_q  <= pos_idx;
      rdok_q <= ({1'b0, position_i} < lim) && ({1'b0, pos_idx} < lim) &&
                ({1'b0, pos_idx} < used_q);
    end
    if (state_q == S_RUN && tok_vld[MAX_COLORS]) begin
      res_hit_q <= tok[MAX_COLORS].hit;
      res_pay_q <= tok[MAX_COLORS].payload;
    end
    if (finish) begin
      case (act_q)
        ecpb_pkg::ActPixel: begin
          index_q <= res_hit_q ? res_pay_q[7:0] : (append ? used_q[7:0] : 8'd0);
          added_q <= append;
          full_q  <= !res_hit_q && !append;
          entry_q <= 32'd0;
        end
        ecpb_pkg::ActRead: begin
          index_q <= 8'd0;
          added_q <= 1'b0;
          full_q  <= 1'b0;
          entry_q <= res_hit_q ? res_pay_q : 32'd0;
        end
        default: begin
          index_q <= 8'd0;
          added_q <= 1'b0;
          full_q  <= 1'b0;
          entry_q <= 32'd0;
        end
      endcase
    end
  end

  // cell chain
  assign tok_vld[0] = start_q;
  assign tok[0]     = '{hit: 1'b0, payload: 32'd0};

  for (genvar k = 0; k < MAX_COLORS; k++) begin : g_cell
    ecpb_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .tok_vld_i(tok_vld[k]),
      .tok_i    (tok[k]),
      .tok_vld_o(tok_vld[k+1]),
      .tok_o    (tok[k+1])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign index_o       = index_q;
  assign added_o       = added_q;
  assign full_res_o    = full_q;
  assign entry_red_o   = entry_q[7:0];
  assign entry_green_o = entry_q[15:8];
  assign entry_blue_o  = entry_q[23:16];
  assign entry_alpha_o = entry_q[31:24];
  assign used_total_o  = used_q;

  `ECPB_ASSERT_NOW(a_used_max, 1'b1, used_q <= MaxCnt)
  `ECPB_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vld))
  `ECPB_ASSERT_NOW(a_idle_empty, in_ready_o, tok_vld[MAX_COLORS:1] == '0)
  `ECPB_ASSERT_NOW(a_flags_excl, out_valid_q, !(added_q && full_q))
  `ECPB_ASSERT_NEXT(a_stall_hold, out_valid_q && !out_ready_i, $stable(used_q))

endmodule

FILE: tb/ecpb_checker.sv
`timescale 1ns / 100ps
// Checker for the palette builder: predicts every result from the input transfers and compares.
module ecpb_checker #(
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic [7:0]  position_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  index_i,
  input  logic        added_i,
  input  logic        full_res_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  input  logic [7:0]  entry_alpha_i,
  input  logic [8:0]  used_total_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          added_count_o,
  output int          full_count_o
);

  localparam int ReportLimit = 40;

  typedef struct packed {
    logic [7:0] index;
    logic       added;
    logic       full_res;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;
    logic [8:0] used_total;
  } palette_result_t;

  logic [31:0]     color_table [256];
  logic [8:0]      colors_used;
  logic            halve_alpha;
  logic [8:0]      entries_cfg;
  palette_result_t result_q [$];

  function automatic int unsigned entry_limit();
    int unsigned lim;
    lim = 32'(entries_cfg);
    if (lim > MAX_COLORS) lim = MAX_COLORS;
    if (lim > 256) lim = 256;
    return lim;
  endfunction

  // file order swaps bits 3 and 4 of the entry index
  function automatic logic [7:0] file_to_entry(logic [7:0] p);
    return {p[7:5], p[3], p[4], p[2:0]};
  endfunction

  // Work out the result of one transfer and advance the palette state.
  function automatic palette_result_t index_color(logic [1:0] act, logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, logic [7:0] a,
                                                  logic [7:0] pos);
    palette_result_t res;
    logic [31:0]     key;
    logic [7:0]      ent;
    logic [7:0]      alpha_eff;
    int unsigned     lim;
    bit              found;
    res   = '0;
    lim   = entry_limit();
    found = 1'b0;
    case (act)
      ecpb_pkg::ActPixel: begin
        alpha_eff = halve_alpha ? (a >> 1) : a;
        key = {alpha_eff, b, g, r};
        for (int c = 0; c < int'(colors_used); c++) begin
          if (!found && color_table[c] == key) begin
            res.index = c[7:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (32'(colors_used) < lim) begin
            color_table[colors_used[7:0]] = key;
            res.index = colors_used[7:0];
            colors_used = colors_used + 9'd1;
            res.added = 1'b1;
          end else begin
            res.full_res = 1'b1;
          end
        end
      end
      ecpb_pkg::ActRead: begin
        ent = file_to_entry(pos);
        if (32'(pos) < lim && 32'(ent) < lim && {1'b0, ent} < colors_used) begin
          {res.entry_alpha, res.entry_blue, res.entry_green, res.entry_red} = color_table[ent];
        end
      end
      ecpb_pkg::ActClear: colors_used = '0;
      default: ;
    endcase
    res.used_total = colors_used;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count_o++;
    if (fail_count_o <= ReportLimit) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    palette_result_t want;
    if (!rst_ni) begin
      result_q.delete();
      colors_used   = '0;
      halve_alpha   = 1'b1;
      entries_cfg   = 9'd256;
      fail_count_o  = 0;
      pending_o     = 0;
      added_count_o = 0;
      full_count_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          ecpb_pkg::RegConvertAlpha:   halve_alpha = pwdata[0];
          ecpb_pkg::RegPaletteEntries: entries_cfg = pwdata[8:0];
          default: ;
        endcase
      end
      // compare before predicting: a result never belongs to the transfer of the same edge
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with index %0h and nothing expected",
                                    index_i));
        end else begin
          want = result_q.pop_front();
          check_field("index", 9'(index_i), 9'(want.index));
          check_field("added", 9'(added_i), 9'(want.added));
          check_field("full_res", 9'(full_res_i), 9'(want.full_res));
          check_field("entry_red", 9'(entry_red_i), 9'(want.entry_red));
          check_field("entry_green", 9'(entry_green_i), 9'(want.entry_green));
          check_field("entry_blue", 9'(entry_blue_i), 9'(want.entry_blue));
          check_field("entry_alpha", 9'(entry_alpha_i), 9'(want.entry_alpha));
          check_field("used_total", used_total_i, want.used_total);
          if (want.added) added_count_o++;
          if (want.full_res) full_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(index_color(action_i, red_i, green_i, blue_i, alpha_i, position_i));
      end
      pending_o = result_q.size();
    end
  end

endmodule

FILE: tb/tb_exact_color_palette_builder.sv
`timescale 1ns / 100ps
// Testbench top for the palette builder: clock, reset, stimulus phases and verdict.
module tb_exact_color_palette_builder;

  localparam int unsigned MaxColors     = 256;
  localparam logic [1:0]  ActIgnored    = 2'd3;
  localparam int          WatchdogLimit = 20000;
  localparam int          HoldOffCycles = 1200;
  localparam int          NumPhases     = 8;
  localparam int          PoolSize      = 24;

  // per phase: register values, idle mix, length and item mix (percent)
  int ph_convert[NumPhases]    = '{1, 0, 1, 0, 1, 1, 1, 0};
  int ph_entries[NumPhases]    = '{256, 1, 16, 0, 256, 20, 33, 200};
  int ph_send_idle[NumPhases]  = '{0, 48, 0, 16, 0, 48, 16, 0};
  int ph_recv_stall[NumPhases] = '{0, 0, 48, 16, 0, 0, 16, 48};
  int ph_items[NumPhases]      = '{150, 150, 150, 100, 330, 150, 180, 250};
  int ph_pixel[NumPhases]      = '{74, 60, 65, 70, 88, 65, 65, 72};
  int ph_read[NumPhases]       = '{21, 33, 29, 25, 10, 30, 30, 24};
  int ph_clear[NumPhases]      = '{3, 5, 4, 3, 0, 3, 3, 2};
  int ph_fresh[NumPhases]      = '{30, 40, 40, 50, 95, 10, 35, 30};
  bit ph_new_pool[NumPhases]   = '{1, 1, 1, 1, 1, 0, 1, 1};
  bit ph_holdoff[NumPhases]    = '{0, 0, 1, 0, 0, 0, 0, 0};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i      = '0;
  logic [7:0]  red_i         = '0;
  logic [7:0]  green_i       = '0;
  logic [7:0]  blue_i        = '0;
  logic [7:0]  alpha_i       = '0;
  logic [7:0]  position_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  index_o;
  logic        added_o;
  logic        full_res_o;
  logic [7:0]  entry_red_o;
  logic [7:0]  entry_green_o;
  logic [7:0]  entry_blue_o;
  logic [7:0]  entry_alpha_o;
  logic [8:0]  used_total_o;

  int          fail_count;
  int          pending;
  int          added_count;
  int          full_count;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          holdoff_go     = 1'b0;
  bit          holdoff_done   = 1'b0;
  int          holdoff_left   = 0;
  int          quiet_cycles   = 0;
  int          settings_seen  = 1;
  int          items_by_action[4] = '{0, 0, 0, 0};
  logic [31:0] color_pool[PoolSize];

  exact_color_palette_builder #(
    .MAX_COLORS(MaxColors)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .alpha_i       (alpha_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .index_o       (index_o),
    .added_o       (added_o),
    .full_res_o    (full_res_o),
    .entry_red_o   (entry_red_o),
    .entry_green_o (entry_green_o),
    .entry_blue_o  (entry_blue_o),
    .entry_alpha_o (entry_alpha_o),
    .used_total_o  (used_total_o)
  );

  ecpb_checker #(
    .MAX_COLORS(MaxColors)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .alpha_i       (alpha_i),
    .position_i    (position_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .index_i       (index_o),
    .added_i       (added_o),
    .full_res_i    (full_res_o),
    .entry_red_i   (entry_red_o),
    .entry_green_i (entry_green_o),
    .entry_blue_i  (entry_blue_o),
    .entry_alpha_i (entry_alpha_o),
    .used_total_i  (used_total_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .added_count_o (added_count),
    .full_count_o  (full_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off that backs the block up.
  always @(negedge clk_i) begin
    if (holdoff_go && !holdoff_done) begin
      holdoff_left = HoldOffCycles;
      holdoff_done = 1'b1;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
               quiet_cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_seen++;
  endtask

  // color is {alpha, blue, green, red}; returns at the falling edge after the transfer
  task automatic send_item(logic [1:0] act, logic [31:0] color, logic [7:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    {alpha_i, blue_i, green_i, red_i} <= color;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    items_by_action[act]++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned counted;
    int unsigned roll;
    int unsigned lim;
    logic [1:0]  act;
    logic [31:0] color;
    logic [7:0]  pos;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: halved alpha, full table size
    send_item(ecpb_pkg::ActPixel, 32'h0000_0000, 8'h00);
    send_item(ecpb_pkg::ActPixel, 32'hffff_ffff, 8'hff);
    send_item(ecpb_pkg::ActPixel, 32'hfeff_ffff, 8'h00);  // alpha fe halves onto entry 1
    send_item(ecpb_pkg::ActPixel, 32'h0100_0000, 8'h00);  // alpha 01 halves onto entry 0
    send_item(ecpb_pkg::ActPixel, 32'h8000_00ff, 8'h00);
    send_item(ecpb_pkg::ActRead, 32'hffff_ffff, 8'h00);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h01);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h02);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h03);           // past the used range
    send_item(ecpb_pkg::ActRead, 32'h0, 8'hff);
    send_item(ActIgnored, 32'hffff_ffff, 8'hff);
    send_item(ecpb_pkg::ActClear, 32'hffff_ffff, 8'hff);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h00);           // table empty
    send_item(ecpb_pkg::ActPixel, 32'h7856_3412, 8'h00);
    in_valid_i <= 1'b0;

    // single-entry table: old color matches, new one overflows
    drain_results();
    write_reg(ecpb_pkg::RegPaletteEntries, 32'd1);
    send_item(ecpb_pkg::ActPixel, 32'h7856_3412, 8'h00);
    send_item(ecpb_pkg::ActPixel, 32'hf0de_bc9a, 8'h00);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h00);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h01);
    in_valid_i <= 1'b0;

    // zero entries and raw alpha: stored entry still matches, reads give zero
    drain_results();
    write_reg(ecpb_pkg::RegConvertAlpha, 32'd0);
    write_reg(ecpb_pkg::RegPaletteEntries, 32'd0);
    send_item(ecpb_pkg::ActPixel, 32'h3c56_3412, 8'h00);
    send_item(ecpb_pkg::ActPixel, 32'h7856_3412, 8'h00);
    send_item(ecpb_pkg::ActRead, 32'h0, 8'h00);
    in_valid_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_reg(ecpb_pkg::RegConvertAlpha, 32'(ph_convert[p]));
      write_reg(ecpb_pkg::RegPaletteEntries, 32'(ph_entries[p]));
      send_idle_pct  = ph_send_idle[p];
      recv_stall_pct = ph_recv_stall[p];
      if (ph_new_pool[p]) begin
        foreach (color_pool[k]) color_pool[k] = $urandom;
      end
      if (ph_holdoff[p]) holdoff_go = 1'b1;
      lim = (ph_entries[p] > MaxColors) ? MaxColors : ph_entries[p];
      counted = 0;
      while (counted < ph_items[p]) begin
        roll  = $urandom_range(99);
        color = $urandom;
        pos   = 8'($urandom);
        if (roll < ph_pixel[p]) begin
          act = ecpb_pkg::ActPixel;
          // reuse pool colors so lookups hit; set alpha bit 0 at random to hit the halving
          if ($urandom_range(99) >= ph_fresh[p]) begin
            color     = color_pool[$urandom_range(PoolSize - 1)];
            color[24] = 1'($urandom_range(1));
          end
        end else if (roll < ph_pixel[p] + ph_read[p]) begin
          act = ecpb_pkg::ActRead;
          if ($urandom_range(1) && lim > 0) pos = 8'($urandom_range(lim - 1));
        end else if (roll < ph_pixel[p] + ph_read[p] + ph_clear[p]) begin
          act = ecpb_pkg::ActClear;
        end else begin
          act = ActIgnored;
        end
        send_item(act, color, pos);
        if (act != ActIgnored) counted++;
      end
      in_valid_i <= 1'b0;
    end

    drain_results();
    repeat (MaxColors + 8) @(posedge clk_i);
    $display("covered %0d pixel, %0d read, %0d clear and %0d unknown-action transfers",
             items_by_action[ecpb_pkg::ActPixel], items_by_action[ecpb_pkg::ActRead],
             items_by_action[ecpb_pkg::ActClear], items_by_action[ActIgnored]);
    $display("%0d register writes, %0d new entries, %0d table-full results, %0d-cycle hold-off",
             settings_seen - 1, added_count, full_count, HoldOffCycles);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
